### rtl/core/clm_pkg.sv
// ----------------------------------------------------------------------------
// clm_pkg
// Shared types, constants and microcode ROM for the core load monitor.
// ----------------------------------------------------------------------------
package clm_pkg;

  localparam int unsigned NUM_CORES = 8;
  localparam int unsigned PTR_W     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int unsigned CNT_W     = $clog2(NUM_CORES + 1);

  localparam int unsigned IDX_W     = 3;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned FREQ_W    = 24;
  localparam int unsigned LOAD_W    = 7;
  localparam int unsigned UTIL_W    = 10;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned LOAD_MAX  = 100;
  localparam int unsigned SUM_W     = $clog2(LOAD_MAX * NUM_CORES + 1);

  // dividend register: 100 * 48-bit difference
  localparam int unsigned REM_W     = TIME_W + LOAD_W;
  localparam int unsigned BIT_W     = $clog2(LOAD_W);

  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam int unsigned PC_W      = 3;

  typedef enum logic [1:0] {
    REG_ONLINE  = 2'd0,
    REG_SUSPEND = 2'd1,
    REG_CL0     = 2'd2,
    REG_CL1     = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_SCALE,
    OP_DIV,
    OP_WRITE,
    OP_WALK,
    OP_AVG,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_IN,
    COND_BITS_LEFT,
    COND_CORES_LEFT,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;   // stay on this step while true
    logic [PC_W-1:0]  nxt;
  } ctl_word_t;

  typedef struct packed {
    logic in_valid;
    logic bits_left;
    logic cores_left;
    logic out_busy;
  } stat_t;

  function automatic ctl_word_t ctl_rom(logic [PC_W-1:0] pc);
    ctl_word_t w;
    unique case (pc)
      3'd0:    w = '{op: OP_ACCEPT, cond: COND_NO_IN,      nxt: 3'd1};
      3'd1:    w = '{op: OP_SCALE,  cond: COND_NONE,       nxt: 3'd2};
      3'd2:    w = '{op: OP_DIV,    cond: COND_BITS_LEFT,  nxt: 3'd3};
      3'd3:    w = '{op: OP_WRITE,  cond: COND_NONE,       nxt: 3'd4};
      3'd4:    w = '{op: OP_WALK,   cond: COND_CORES_LEFT, nxt: 3'd5};
      3'd5:    w = '{op: OP_AVG,    cond: COND_NONE,       nxt: 3'd6};
      3'd6:    w = '{op: OP_DIV,    cond: COND_BITS_LEFT,  nxt: 3'd7};
      default: w = '{op: OP_EMIT,   cond: COND_OUT_BUSY,   nxt: 3'd0};
    endcase
    return w;
  endfunction

  // membership of core c in an 8-bit mask; cores past the mask are out
  function automatic logic in_mask(logic [MASK_W-1:0] m, logic [PTR_W-1:0] c);
    logic [31:0] e;
    e = 32'(m);
    return e[5'(c)];
  endfunction

endpackage

### rtl/core/clm_seq.sv
// ----------------------------------------------------------------------------
// clm_seq
// Microcode sequencer: step counter, control ROM and hold/jump logic.
// ----------------------------------------------------------------------------
module clm_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clm_pkg::stat_t stat_i,
  output clm_pkg::op_e   op_o
);

  logic [clm_pkg::PC_W-1:0] pc_q, pc_d;
  clm_pkg::ctl_word_t       ctl;
  logic                     hold;

  always_comb begin
    ctl = clm_pkg::ctl_rom(pc_q);
    unique case (ctl.cond)
      clm_pkg::COND_NO_IN:      hold = !stat_i.in_valid;
      clm_pkg::COND_BITS_LEFT:  hold = stat_i.bits_left;
      clm_pkg::COND_CORES_LEFT: hold = stat_i.cores_left;
      clm_pkg::COND_OUT_BUSY:   hold = stat_i.out_busy;
      default:                  hold = 1'b0;
    endcase
    pc_d = hold ? pc_q : ctl.nxt;
    op_o = ctl.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/core/core_load_monitor_top.sv
// One word is processed at a time: the block takes no new word until it has run two
// 7-step bit-serial divides in the shared divider and the one-core-per-cycle table walk
// and loaded the result register.
// A new word is taken while the previous result still waits on out_stall_i.
// Reset: asynchronous, active low; clears the load and frequency tables, the
// configuration registers to their defaults and all handshake state.
// ----------------------------------------------------------------------------
// core_load_monitor_top
// Per-core load bookkeeping with online, least-busy and cluster statistics.
// ----------------------------------------------------------------------------
module core_load_monitor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clm_pkg::ADDR_W-1:0]    paddr,
  input  logic [clm_pkg::DATA_W-1:0]    pwdata,
  output logic [clm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [clm_pkg::IDX_W-1:0]     core_index_i,
  input  logic [clm_pkg::TIME_W-1:0]    idle_time_i,
  input  logic [clm_pkg::TIME_W-1:0]    window_time_i,
  input  logic [clm_pkg::FREQ_W-1:0]    core_frequency_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [clm_pkg::LOAD_W-1:0]    sample_load_o,
  output logic [clm_pkg::UTIL_W-1:0]    online_load_sum_o,
  output logic [clm_pkg::FREQ_W-1:0]    last_online_freq_o,
  output logic [clm_pkg::LOAD_W-1:0]    average_load_o,
  output logic [clm_pkg::IDX_W-1:0]     least_busy_core_o,
  output logic [clm_pkg::UTIL_W-1:0]    cluster_zero_util_o,
  output logic [clm_pkg::FREQ_W-1:0]    cluster_zero_freq_o,
  output logic [clm_pkg::UTIL_W-1:0]    cluster_one_util_o,
  output logic [clm_pkg::FREQ_W-1:0]    cluster_one_freq_o
);

  localparam int unsigned PTR_W  = clm_pkg::PTR_W;
  localparam int unsigned REM_W  = clm_pkg::REM_W;
  localparam int unsigned LOAD_W = clm_pkg::LOAD_W;
  localparam int unsigned FREQ_W = clm_pkg::FREQ_W;
  localparam int unsigned UTIL_W = clm_pkg::UTIL_W;
  localparam int unsigned SUM_W  = clm_pkg::SUM_W;
  localparam int unsigned CNT_W  = clm_pkg::CNT_W;
  localparam int unsigned BIT_W  = clm_pkg::BIT_W;
  localparam int unsigned MASK_W = clm_pkg::MASK_W;

  // configuration
  logic [MASK_W-1:0] online_q, cl0_q, cl1_q;
  logic              suspend_q;
  logic              cfg_wr;

  // sequencer
  clm_pkg::op_e   op;
  clm_pkg::stat_t stat;
  logic           in_acc;
  logic           out_load;

  // tables
  logic [LOAD_W-1:0] load_tab_q [clm_pkg::NUM_CORES];
  logic [FREQ_W-1:0] freq_tab_q [clm_pkg::NUM_CORES];

  // control counters
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  logic [REM_W-1:0]            rem_q, rem_d, dsh_q, dsh_d;
  logic [LOAD_W-1:0]           quo_q, quo_d;
  logic [clm_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [FREQ_W-1:0]           frq_q, frq_d;
  logic [LOAD_W-1:0]           smp_q, smp_d;
  logic [SUM_W-1:0]            sum_q, sum_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [FREQ_W-1:0]           last_q, last_d;
  logic [LOAD_W-1:0]           bestl_q, bestl_d;
  logic [PTR_W-1:0]            bestc_q, bestc_d;
  logic [UTIL_W-1:0]           c0u_q, c0u_d, c1u_q, c1u_d;
  logic [FREQ_W-1:0]           c0f_q, c0f_d, c1f_q, c1f_d;

  // walk tap
  logic [LOAD_W-1:0] ld;
  logic [FREQ_W-1:0] fr;
  logic              on, ge;
  logic [REM_W-1:0]  diff_rem;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q  <= 8'd255;
      suspend_q <= 1'b0;
      cl0_q     <= 8'd15;
      cl1_q     <= 8'd240;
    end else if (cfg_wr) begin
      unique case (clm_pkg::reg_e'(paddr[3:2]))
        clm_pkg::REG_ONLINE:  online_q  <= pwdata[MASK_W-1:0];
        clm_pkg::REG_SUSPEND: suspend_q <= pwdata[0];
        clm_pkg::REG_CL0:     cl0_q     <= pwdata[MASK_W-1:0];
        clm_pkg::REG_CL1:     cl1_q     <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (clm_pkg::reg_e'(paddr[3:2]))
      clm_pkg::REG_ONLINE:  prdata = 32'(online_q);
      clm_pkg::REG_SUSPEND: prdata = 32'(suspend_q);
      clm_pkg::REG_CL0:     prdata = 32'(cl0_q);
      clm_pkg::REG_CL1:     prdata = 32'(cl1_q);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_stall_o = (op != clm_pkg::OP_ACCEPT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (op == clm_pkg::OP_EMIT) && !stat.out_busy;

  always_comb begin
    stat.in_valid   = in_valid_i;
    stat.bits_left  = (bit_q != '0);
    stat.cores_left = (ptr_q != PTR_W'(clm_pkg::NUM_CORES - 1));
    stat.out_busy   = out_valid_q && out_stall_i;
  end

  clm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  assign ld       = load_tab_q[ptr_q];
  assign fr       = freq_tab_q[ptr_q];
  assign on       = clm_pkg::in_mask(online_q, ptr_q);
  assign ge       = (rem_q >= dsh_q);
  assign diff_rem = (window_time_i > idle_time_i) ?
                    REM_W'(window_time_i - idle_time_i) : '0;

  always_comb begin
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    bit_d   = bit_q;
    idx_d   = idx_q;
    frq_d   = frq_q;
    smp_d   = smp_q;
    ptr_d   = ptr_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    bestl_d = bestl_q;
    bestc_d = bestc_q;
    c0u_d   = c0u_q;
    c0f_d   = c0f_q;
    c1u_d   = c1u_q;
    c1f_d   = c1f_q;

    unique case (op)
      clm_pkg::OP_ACCEPT: begin
        if (in_acc) begin
          idx_d = core_index_i;
          frq_d = core_frequency_i;
          rem_d = diff_rem;
          // zero divisor only with zero dividend: all-ones keeps the quotient 0
          dsh_d = (window_time_i == '0) ? '1 : (REM_W'(window_time_i) << (LOAD_W - 1));
          bit_d = BIT_W'(LOAD_W - 1);
        end
      end
      clm_pkg::OP_SCALE: begin
        rem_d = (rem_q << 6) + (rem_q << 5) + (rem_q << 2);
      end
      clm_pkg::OP_DIV: begin
        rem_d = ge ? (rem_q - dsh_q) : rem_q;
        quo_d = {quo_q[LOAD_W-2:0], ge};
        dsh_d = dsh_q >> 1;
        bit_d = bit_q - 1'b1;
      end
      clm_pkg::OP_WRITE: begin
        smp_d   = quo_q;
        ptr_d   = '0;
        sum_d   = '0;
        cnt_d   = '0;
        last_d  = '0;
        bestl_d = LOAD_W'(clm_pkg::LOAD_MAX);
        bestc_d = PTR_W'(1);
        c0u_d   = '0;
        c0f_d   = '0;
        c1u_d   = '0;
        c1f_d   = '0;
      end
      clm_pkg::OP_WALK: begin
        if (on) begin
          sum_d  = sum_q + SUM_W'(ld);
          cnt_d  = cnt_q + 1'b1;
          last_d = fr;
          if ((ptr_q > PTR_W'(!suspend_q)) && (ld <= bestl_q)) begin
            bestl_d = ld;
            bestc_d = ptr_q;
          end
        end
        if (clm_pkg::in_mask(cl0_q, ptr_q)) begin
          c0f_d = fr;
          if (on) c0u_d = c0u_q + UTIL_W'(ld);
        end
        if (clm_pkg::in_mask(cl1_q, ptr_q)) begin
          c1f_d = fr;
          if (on) c1u_d = c1u_q + UTIL_W'(ld);
        end
        ptr_d = ptr_q + 1'b1;
      end
      clm_pkg::OP_AVG: begin
        rem_d = REM_W'(sum_q);
        dsh_d = (cnt_q == '0) ? '1 : (REM_W'(cnt_q) << (LOAD_W - 1));
        bit_d = BIT_W'(LOAD_W - 1);
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bit_q       <= bit_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    idx_q   <= idx_d;
    frq_q   <= frq_d;
    smp_q   <= smp_d;
    sum_q   <= sum_d;
    cnt_q   <= cnt_d;
    last_q  <= last_d;
    bestl_q <= bestl_d;
    bestc_q <= bestc_d;
    c0u_q   <= c0u_d;
    c0f_q   <= c0f_d;
    c1u_q   <= c1u_d;
    c1f_q   <= c1f_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < clm_pkg::NUM_CORES; i++) begin
        load_tab_q[i] <= '0;
        freq_tab_q[i] <= '0;
      end
    end else if ((op == clm_pkg::OP_WRITE) && (32'(idx_q) < clm_pkg::NUM_CORES)) begin
      load_tab_q[PTR_W'(idx_q)] <= quo_q;
      freq_tab_q[PTR_W'(idx_q)] <= frq_q;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_load_o       <= smp_q;
      online_load_sum_o   <= UTIL_W'(sum_q);
      last_online_freq_o  <= last_q;
      average_load_o      <= quo_q;
      least_busy_core_o   <= clm_pkg::IDX_W'(bestc_q);
      cluster_zero_util_o <= c0u_q;
      cluster_zero_freq_o <= c0f_q;
      cluster_one_util_o  <= c1u_q;
      cluster_one_freq_o  <= c1f_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/clm_checker.sv
// ----------------------------------------------------------------------------
// clm_checker
// Port-level checks on the core load monitor, bound to the top level.
// ----------------------------------------------------------------------------
module clm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [clm_pkg::LOAD_W-1:0] sample_load_o,
  input logic [clm_pkg::LOAD_W-1:0] average_load_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // one word at a time: busy right after taking one
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while a word is in progress");

  // a result cannot appear the cycle after a word is taken
  a_no_quick_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result raised too early");

  // load percentages stay in range
  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_load_o <= clm_pkg::LOAD_W'(clm_pkg::LOAD_MAX)) &&
                    (average_load_o <= clm_pkg::LOAD_W'(clm_pkg::LOAD_MAX)))
    else $error("load percentage above 100");

endmodule

bind core_load_monitor_top clm_checker u_clm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sample_load_o  (sample_load_o),
  .average_load_o (average_load_o)
);

### tb/sv/clm_load_checker.sv
// ----------------------------------------------------------------------------
// clm_load_checker
// Watches the configuration port and both word channels of the core load
// monitor. Keeps its own copy of the registers and the per-core load and
// frequency tables, predicts the report for every accepted sample word and
// compares each accepted result word, field by field, with the oldest
// prediction. Hands the mismatch count and the number of reports still due
// to the testbench top.
// ----------------------------------------------------------------------------
module clm_load_checker
  import clm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [ADDR_W-1:0]   paddr_i,
  input  logic [DATA_W-1:0]   pwdata_i,

  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [IDX_W-1:0]    core_index_i,
  input  logic [TIME_W-1:0]   idle_time_i,
  input  logic [TIME_W-1:0]   window_time_i,
  input  logic [FREQ_W-1:0]   core_frequency_i,

  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [LOAD_W-1:0]   sample_load_i,
  input  logic [UTIL_W-1:0]   online_load_sum_i,
  input  logic [FREQ_W-1:0]   last_online_freq_i,
  input  logic [LOAD_W-1:0]   average_load_i,
  input  logic [IDX_W-1:0]    least_busy_core_i,
  input  logic [UTIL_W-1:0]   cluster_zero_util_i,
  input  logic [FREQ_W-1:0]   cluster_zero_freq_i,
  input  logic [UTIL_W-1:0]   cluster_one_util_i,
  input  logic [FREQ_W-1:0]   cluster_one_freq_i,

  output int                  pending_o,
  output int                  err_cnt_o
);

  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic [UTIL_W-1:0] sum;
    logic [FREQ_W-1:0] last_freq;
    logic [LOAD_W-1:0] avg;
    logic [IDX_W-1:0]  least;
    logic [UTIL_W-1:0] c0_util;
    logic [FREQ_W-1:0] c0_freq;
    logic [UTIL_W-1:0] c1_util;
    logic [FREQ_W-1:0] c1_freq;
  } load_report_t;

  logic [MASK_W-1:0] online_mask;
  logic              suspend;
  logic [MASK_W-1:0] cl0_mask;
  logic [MASK_W-1:0] cl1_mask;

  logic [LOAD_W-1:0] load_tab [NUM_CORES];
  logic [FREQ_W-1:0] freq_tab [NUM_CORES];

  load_report_t      due_reports [$];
  int                mismatches = 0;

  assign err_cnt_o = mismatches;

  function automatic logic [LOAD_W-1:0] window_load(logic [TIME_W-1:0] idle,
                                                     logic [TIME_W-1:0] win);
    logic [63:0] busy;
    if (win <= idle) return '0;
    busy = 64'(win - idle) * 64'd100;
    return LOAD_W'(busy / 64'(win));
  endfunction

  function automatic void cluster_stat(input  logic [MASK_W-1:0] m,
                                       output logic [UTIL_W-1:0] util,
                                       output logic [FREQ_W-1:0] freq);
    int unsigned s;
    s    = 0;
    freq = '0;
    for (int c = 0; c < NUM_CORES; c++) begin
      if (m[c]) begin
        if (online_mask[c]) s += load_tab[c];
        freq = freq_tab[c];
      end
    end
    util = UTIL_W'(s);
  endfunction

  // updates the tables, then walks them
  function automatic load_report_t predict_report(logic [IDX_W-1:0]  core,
                                                  logic [TIME_W-1:0] idle,
                                                  logic [TIME_W-1:0] win,
                                                  logic [FREQ_W-1:0] freq);
    load_report_t      r;
    int unsigned       sum;
    int unsigned       count;
    int unsigned       best_load;
    int                best_core;
    int                min_core;
    logic [FREQ_W-1:0] last;
    sum       = 0;
    count     = 0;
    best_load = LOAD_MAX;
    best_core = 1;
    last      = '0;
    r.load    = window_load(idle, win);
    if (core < NUM_CORES) begin
      load_tab[core] = r.load;
      freq_tab[core] = freq;
    end
    min_core = suspend ? 0 : 1;
    for (int c = 0; c < NUM_CORES; c++) begin
      if (online_mask[c]) begin
        sum += load_tab[c];
        last = freq_tab[c];
        count++;
        // ties go to the higher core
        if (c > min_core && load_tab[c] <= best_load) begin
          best_load = load_tab[c];
          best_core = c;
        end
      end
    end
    r.sum       = UTIL_W'(sum);
    r.last_freq = last;
    r.avg       = LOAD_W'(count != 0 ? sum / count : 0);
    r.least     = IDX_W'(best_core);
    cluster_stat(cl0_mask, r.c0_util, r.c0_freq);
    cluster_stat(cl1_mask, r.c1_util, r.c1_freq);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    load_report_t r;
    if (!rst_ni) begin
      online_mask = 8'd255;
      suspend     = 1'b0;
      cl0_mask    = 8'd15;
      cl1_mask    = 8'd240;
      for (int c = 0; c < NUM_CORES; c++) begin
        load_tab[c] = '0;
        freq_tab[c] = '0;
      end
      due_reports.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[ADDR_W-1:2]))
          REG_ONLINE:  online_mask = pwdata_i[MASK_W-1:0];
          REG_SUSPEND: suspend     = pwdata_i[0];
          REG_CL0:     cl0_mask    = pwdata_i[MASK_W-1:0];
          REG_CL1:     cl1_mask    = pwdata_i[MASK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_reports.size() == 0) begin
          $error("result word with no sample outstanding");
          mismatches++;
        end else begin
          r = due_reports.pop_front();
          check_field("sample_load",       r.load,      sample_load_i);
          check_field("online_load_sum",   r.sum,       online_load_sum_i);
          check_field("last_online_freq",  r.last_freq, last_online_freq_i);
          check_field("average_load",      r.avg,       average_load_i);
          check_field("least_busy_core",   r.least,     least_busy_core_i);
          check_field("cluster_zero_util", r.c0_util,   cluster_zero_util_i);
          check_field("cluster_zero_freq", r.c0_freq,   cluster_zero_freq_i);
          check_field("cluster_one_util",  r.c1_util,   cluster_one_util_i);
          check_field("cluster_one_freq",  r.c1_freq,   cluster_one_freq_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_reports.push_back(predict_report(core_index_i, idle_time_i,
                                             window_time_i, core_frequency_i));
      end
      pending_o <= due_reports.size();
    end
  end

endmodule

### tb/sv/tb_core_load_monitor_top.sv
// ----------------------------------------------------------------------------
// tb_core_load_monitor_top
// Drives load sample words and register writes into the core load monitor
// and gives the verdict. A short directed run covers the extreme windows,
// frequencies and least-busy ties; then random phases, each under its own
// register setting and one of four idling patterns, exercise empty and full masks, the
// suspend search and the cluster statistics. Checking is done by
// clm_load_checker beside the block.
// ----------------------------------------------------------------------------
module tb_core_load_monitor_top;
  import clm_pkg::*;

  localparam int unsigned NUM_PHASES      = 11;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned DRAIN_CYCLES    = 40;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;

  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ADDR_W-1:0]   paddr          = '0;
  logic [DATA_W-1:0]   pwdata         = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [IDX_W-1:0]    core_index     = '0;
  logic [TIME_W-1:0]   idle_time      = '0;
  logic [TIME_W-1:0]   window_time    = '0;
  logic [FREQ_W-1:0]   core_frequency = '0;

  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [LOAD_W-1:0]   sample_load;
  logic [UTIL_W-1:0]   online_load_sum;
  logic [FREQ_W-1:0]   last_online_freq;
  logic [LOAD_W-1:0]   average_load;
  logic [IDX_W-1:0]    least_busy_core;
  logic [UTIL_W-1:0]   cluster_zero_util;
  logic [FREQ_W-1:0]   cluster_zero_freq;
  logic [UTIL_W-1:0]   cluster_one_util;
  logic [FREQ_W-1:0]   cluster_one_freq;

  int unsigned         send_gap_pct   = 0;
  int unsigned         stall_pct      = 0;
  int unsigned         quiet_cycles   = 0;
  int                  pending;
  int                  err_cnt;

  core_load_monitor_top dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .core_index_i        (core_index),
    .idle_time_i         (idle_time),
    .window_time_i       (window_time),
    .core_frequency_i    (core_frequency),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .sample_load_o       (sample_load),
    .online_load_sum_o   (online_load_sum),
    .last_online_freq_o  (last_online_freq),
    .average_load_o      (average_load),
    .least_busy_core_o   (least_busy_core),
    .cluster_zero_util_o (cluster_zero_util),
    .cluster_zero_freq_o (cluster_zero_freq),
    .cluster_one_util_o  (cluster_one_util),
    .cluster_one_freq_o  (cluster_one_freq)
  );

  clm_load_checker u_load_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .psel_i              (psel),
    .penable_i           (penable),
    .pwrite_i            (pwrite),
    .pready_i            (pready),
    .paddr_i             (paddr),
    .pwdata_i            (pwdata),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .core_index_i        (core_index),
    .idle_time_i         (idle_time),
    .window_time_i       (window_time),
    .core_frequency_i    (core_frequency),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .sample_load_i       (sample_load),
    .online_load_sum_i   (online_load_sum),
    .last_online_freq_i  (last_online_freq),
    .average_load_i      (average_load),
    .least_busy_core_i   (least_busy_core),
    .cluster_zero_util_i (cluster_zero_util),
    .cluster_zero_freq_i (cluster_zero_freq),
    .cluster_one_util_i  (cluster_one_util),
    .cluster_one_freq_i  (cluster_one_freq),
    .pending_o           (pending),
    .err_cnt_o           (err_cnt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // leaves the port selected; the caller closes the transfer
  task automatic reg_write(input reg_e idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // upper data bits are junk and must be ignored
  task automatic write_config(input logic [MASK_W-1:0] online, input logic susp,
                              input logic [MASK_W-1:0] cl0, input logic [MASK_W-1:0] cl1);
    reg_write(REG_ONLINE,  {24'($urandom()), online});
    reg_write(REG_SUSPEND, {31'($urandom()), susp});
    reg_write(REG_CL0,     {24'($urandom()), cl0});
    reg_write(REG_CL1,     {24'($urandom()), cl1});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_sample(input logic [IDX_W-1:0] c, input logic [TIME_W-1:0] idle,
                             input logic [TIME_W-1:0] win, input logic [FREQ_W-1:0] freq);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    core_index     <= c;
    idle_time      <= idle;
    window_time    <= win;
    core_frequency <= freq;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_sample();
    logic [TIME_W-1:0] idle;
    logic [TIME_W-1:0] win;
    logic [FREQ_W-1:0] freq;
    int unsigned       shape;
    shape = $urandom_range(5);
    win   = TIME_W'({$urandom(), $urandom()});
    idle  = TIME_W'({$urandom(), $urandom()});
    case (shape)
      1: begin
        win  = TIME_W'(100);
        idle = TIME_W'($urandom_range(100));
      end
      2: begin
        win  = TIME_W'($urandom_range(200));
        idle = TIME_W'($urandom_range(200));
      end
      3: idle = win >> $urandom_range(TIME_W);
      4: win = idle >> $urandom_range(TIME_W);
      5: idle = win - TIME_W'($urandom_range(3));
      default: ;
    endcase
    if ($urandom_range(7) == 0) begin
      freq = $urandom_range(1) ? FREQ_MAX : '0;
    end else begin
      freq = FREQ_W'($urandom());
    end
    send_sample(IDX_W'($urandom_range(NUM_CORES - 1)), idle, win, freq);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme windows and frequencies under the reset setting
    send_sample(3'd0, '0,           '0,       '0);
    send_sample(3'd7, '0,           TIME_MAX, FREQ_MAX);
    send_sample(3'd1, TIME_MAX,     TIME_MAX, 24'd1);
    send_sample(3'd2, TIME_MAX,     '0,       FREQ_MAX);
    send_sample(3'd3, '0,           48'd1,    24'h5A5A5A);
    send_sample(3'd4, 48'd1,        48'd3,    24'hA5A5A5);
    send_sample(3'd5, TIME_MAX - 1, TIME_MAX, 24'd1000);
    send_sample(3'd6, 48'd1,        TIME_MAX, 24'd2000);
    send_sample(3'd2, '0,           48'd100,  24'd3000);
    // equal loads everywhere: least-busy tie goes to the highest core
    for (int c = 0; c < NUM_CORES; c++) begin
      send_sample(IDX_W'(c), 48'd50, 48'd100, FREQ_W'(c * 1000));
    end
    send_sample(3'd7, 48'd99, 48'd100, FREQ_MAX);

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        1: write_config(8'h00, 1'b1, 8'hFF, 8'h00);
        2: write_config(8'hFF, 1'b0, 8'h00, 8'hFF);
        3: write_config(8'h03, 1'b0, 8'h81, 8'h7E);
        4: write_config(8'h02, 1'b1, 8'h0F, 8'hF0);
        default: write_config(MASK_W'($urandom()), 1'($urandom()),
                              MASK_W'($urandom()), MASK_W'($urandom()));
      endcase
      case (ph % 4)
        1: begin
          send_gap_pct = 59;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 59;
        end
        3: begin
          send_gap_pct = 18;
          stall_pct    = 18;
        end
        default: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 6 && n == ITEMS_PER_PHASE / 2) wait_drained();
        send_random_sample();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
